// File: rtl/rrs_pkg.sv
// ----------------------------------------------------------------------------
// rrs_pkg: shared types and constants of the ray range sensor block
// Word formats, register indexes, CORDIC step angles, edge unit request and
// response bundles.
// ----------------------------------------------------------------------------
package rrs_pkg;

  localparam int COORD_W    = 32;
  localparam int ANGLE_W    = 16;
  localparam int FRAC_W     = 17;
  localparam int READING_W  = 16;
  localparam int LEN_W      = 31;
  localparam int CFG_DATA_W = 31;
  localparam int CFG_IDX_W  = 2;
  localparam int CORDIC_W   = 34;
  localparam int CORDIC_STEPS = 16;
  localparam int STEP_W     = 4;
  localparam int RAY_W      = 34;
  localparam int PROD_W     = 68;
  localparam int REM_W      = 69;
  localparam int DIV_STEPS  = 17;

  localparam logic [CFG_IDX_W-1:0] REG_SENSOR_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_READING_SCALE = 2'd1;

  localparam logic OP_SENSE = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  localparam logic [LEN_W-1:0]     SENSOR_LENGTH_RST = 31'd655360;
  localparam logic [READING_W-1:0] READING_SCALE_RST = 16'd65535;
  localparam logic [FRAC_W-1:0]    FRAC_ONE          = 17'h10000;
  localparam logic [ANGLE_W-1:0]   QUARTER_TURN      = 16'h4000;
  localparam logic signed [CORDIC_W-1:0] CORDIC_X0   = 34'sd652032874;

  typedef struct packed {
    logic                      opcode;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic [ANGLE_W-1:0]        heading;
    logic signed [COORD_W-1:0] corner0_x;
    logic signed [COORD_W-1:0] corner0_y;
    logic signed [COORD_W-1:0] corner1_x;
    logic signed [COORD_W-1:0] corner1_y;
    logic signed [COORD_W-1:0] corner2_x;
    logic signed [COORD_W-1:0] corner2_y;
    logic signed [COORD_W-1:0] corner3_x;
    logic signed [COORD_W-1:0] corner3_y;
  } in_word_t;

  typedef struct packed {
    logic [5:0]           ray_index;
    logic [READING_W-1:0] reading;
    logic                 last;
  } out_word_t;

  typedef struct packed {
    logic     clear;
    in_word_t word;
  } item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
    logic signed [RAY_W-1:0]   rx;
    logic signed [RAY_W-1:0]   ry;
    logic signed [COORD_W-1:0] ax;
    logic signed [COORD_W-1:0] ay;
    logic signed [COORD_W-1:0] bx;
    logic signed [COORD_W-1:0] by;
  } edge_req_t;

  typedef struct packed {
    logic              hit;
    logic [FRAC_W-1:0] frac;
  } edge_rsp_t;

  function automatic logic signed [CORDIC_W-1:0] atan_step(input logic [STEP_W-1:0] k);
    logic signed [CORDIC_W-1:0] r;
    case (k)
      4'd0:    r = 34'sd536870912;
      4'd1:    r = 34'sd316933406;
      4'd2:    r = 34'sd167458907;
      4'd3:    r = 34'sd85004756;
      4'd4:    r = 34'sd42667331;
      4'd5:    r = 34'sd21354465;
      4'd6:    r = 34'sd10679838;
      4'd7:    r = 34'sd5340245;
      4'd8:    r = 34'sd2670163;
      4'd9:    r = 34'sd1335087;
      4'd10:   r = 34'sd667544;
      4'd11:   r = 34'sd333772;
      4'd12:   r = 34'sd166886;
      4'd13:   r = 34'sd83443;
      4'd14:   r = 34'sd41722;
      default: r = 34'sd20861;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/ray_range_sensor_update.sv
// ----------------------------------------------------------------------------
// ray_range_sensor_update: simulated range sensors against a quadrilateral
// Casts SENSOR_COUNT rays per sense word, keeps the nearest hit fraction per
// ray and reports scaled readings for all rays after every word.
// ----------------------------------------------------------------------------
// Clear word: readings at one per cycle unless the output stalls.
// Sense word: per ray a CORDIC run and scaling, plus per edge the
//   cross-product checks and, on a hit, the bit-serial divider,
//   then SENSOR_COUNT readings at one per cycle unless the output stalls.
// Two words queue at the input while the back end works.
// Reset (synchronous): registers to their defaults, all fractions to 1.0.
module ray_range_sensor_update import rrs_pkg::*; #(
  parameter int SENSOR_COUNT = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_word_t              in_word,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_word_t             out_word,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int IDX_W = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;
  localparam int R_W   = IDX_W + 1;
  localparam logic [IDX_W-1:0]   LAST_RAY = IDX_W'(SENSOR_COUNT - 1);
  localparam logic [ANGLE_W-1:0] BASE_Q   = ANGLE_W'(65536 / SENSOR_COUNT);
  localparam logic [R_W-1:0]     BASE_R   = R_W'(65536 % SENSOR_COUNT);
  localparam logic [R_W-1:0]     N_R      = R_W'(SENSOR_COUNT);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_RAY    = 7'b0000010,
    S_CORDIC = 7'b0000100,
    S_SCALE  = 7'b0001000,
    S_EDGE   = 7'b0010000,
    S_EWAIT  = 7'b0100000,
    S_EMIT   = 7'b1000000
  } seq_state_t;

  seq_state_t st;

  logic [LEN_W-1:0]     sensor_length;
  logic [READING_W-1:0] reading_scale;

  logic                 item_valid;
  logic                 item_pop;
  item_t                item;
  item_t                cur;

  logic [FRAC_W-1:0]    frac [SENSOR_COUNT];
  logic [FRAC_W-1:0]    best;
  logic [FRAC_W-1:0]    best_upd;
  logic [IDX_W-1:0]     ray;
  logic [ANGLE_W-1:0]   base;
  logic [R_W-1:0]       base_r;
  logic [R_W-1:0]       r_sum;
  logic [ANGLE_W-1:0]   base_next;
  logic [R_W-1:0]       base_r_next;
  logic [1:0]           edge_sel;

  logic                       cordic_start;
  logic                       cordic_done;
  logic [ANGLE_W-1:0]         angle;
  logic signed [CORDIC_W-1:0] sin_q30;
  logic signed [CORDIC_W-1:0] cos_q30;
  logic signed [COORD_W-1:0]  len_s;
  logic signed [65:0]         prod_x;
  logic signed [65:0]         prod_y;
  logic signed [RAY_W-1:0]    rx;
  logic signed [RAY_W-1:0]    ry;

  logic       edge_start;
  logic       edge_done;
  edge_req_t  edge_req;
  edge_rsp_t  edge_rsp;

  logic [32:0] scaled;

  rrs_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_word    (in_word),
    .item_valid (item_valid),
    .item_pop   (item_pop),
    .item       (item)
  );

  rrs_cordic u_cordic (
    .clk     (clk),
    .rst     (rst),
    .start   (cordic_start),
    .angle   (angle),
    .done    (cordic_done),
    .sin_q30 (sin_q30),
    .cos_q30 (cos_q30)
  );

  rrs_edge u_edge (
    .clk   (clk),
    .rst   (rst),
    .start (edge_start),
    .req   (edge_req),
    .done  (edge_done),
    .rsp   (edge_rsp)
  );

  assign item_pop = (st == S_IDLE);
  assign angle    = base - cur.word.heading + QUARTER_TURN;
  assign len_s    = {1'b0, sensor_length};
  assign prod_x   = len_s * sin_q30;
  assign prod_y   = len_s * cos_q30;
  assign scaled   = reading_scale * frac[ray];

  always_comb begin
    r_sum       = base_r + BASE_R;
    base_next   = base + BASE_Q;
    base_r_next = r_sum;
    if (r_sum >= N_R) begin
      base_r_next = r_sum - N_R;
      base_next   = base + BASE_Q + 16'd1;
    end
    best_upd = (edge_rsp.hit && (edge_rsp.frac < best)) ? edge_rsp.frac : best;
  end

  always_comb begin
    edge_req.px = cur.word.pos_x;
    edge_req.py = cur.word.pos_y;
    edge_req.rx = rx;
    edge_req.ry = ry;
    case (edge_sel)
      2'd0: begin
        edge_req.ax = cur.word.corner0_x;
        edge_req.ay = cur.word.corner0_y;
        edge_req.bx = cur.word.corner1_x;
        edge_req.by = cur.word.corner1_y;
      end
      2'd1: begin
        edge_req.ax = cur.word.corner1_x;
        edge_req.ay = cur.word.corner1_y;
        edge_req.bx = cur.word.corner2_x;
        edge_req.by = cur.word.corner2_y;
      end
      2'd2: begin
        edge_req.ax = cur.word.corner2_x;
        edge_req.ay = cur.word.corner2_y;
        edge_req.bx = cur.word.corner3_x;
        edge_req.by = cur.word.corner3_y;
      end
      default: begin
        edge_req.ax = cur.word.corner3_x;
        edge_req.ay = cur.word.corner3_y;
        edge_req.bx = cur.word.corner0_x;
        edge_req.by = cur.word.corner0_y;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sensor_length <= SENSOR_LENGTH_RST;
      reading_scale <= READING_SCALE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SENSOR_LENGTH: sensor_length <= cfg_data[LEN_W-1:0];
        REG_READING_SCALE: reading_scale <= cfg_data[READING_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st           <= S_IDLE;
      out_valid    <= 1'b0;
      cordic_start <= 1'b0;
      edge_start   <= 1'b0;
      for (int i = 0; i < SENSOR_COUNT; i++) frac[i] <= FRAC_ONE;
    end else begin
      cordic_start <= (st == S_RAY);
      edge_start   <= (st == S_EDGE);
      if (out_valid && out_ready && (st != S_EMIT)) out_valid <= 1'b0;
      unique case (st)
        S_IDLE: begin
          if (item_valid) begin
            cur    <= item;
            ray    <= '0;
            base   <= '0;
            base_r <= '0;
            if (item.clear) begin
              for (int i = 0; i < SENSOR_COUNT; i++) frac[i] <= FRAC_ONE;
              st <= S_EMIT;
            end else begin
              st <= S_RAY;
            end
          end
        end
        S_RAY: begin
          st <= S_CORDIC;
        end
        S_CORDIC: begin
          if (cordic_done) st <= S_SCALE;
        end
        S_SCALE: begin
          rx       <= prod_x[63:30];
          ry       <= prod_y[63:30];
          best     <= frac[ray];
          edge_sel <= 2'd0;
          st       <= S_EDGE;
        end
        S_EDGE: begin
          st <= S_EWAIT;
        end
        S_EWAIT: begin
          if (edge_done) begin
            if (edge_sel == 2'd3) begin
              frac[ray] <= best_upd;
              if (ray == LAST_RAY) begin
                ray <= '0;
                st  <= S_EMIT;
              end else begin
                ray    <= ray + 1'b1;
                base   <= base_next;
                base_r <= base_r_next;
                st     <= S_RAY;
              end
            end else begin
              best     <= best_upd;
              edge_sel <= edge_sel + 2'd1;
              st       <= S_EDGE;
            end
          end
        end
        S_EMIT: begin
          if (!out_valid || out_ready) begin
            out_valid          <= 1'b1;
            out_word.ray_index <= 6'(ray);
            out_word.reading   <= scaled[31:16];
            out_word.last      <= (ray == LAST_RAY);
            if (ray == LAST_RAY) st <= S_IDLE;
            else ray <= ray + 1'b1;
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/rrs_front.sv
// ----------------------------------------------------------------------------
// rrs_front: input side of the ray range sensor
// Accepts input words, marks clear commands and holds them in a two-entry
// queue for the back end.
// ----------------------------------------------------------------------------
module rrs_front import rrs_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_word_t in_word,
  output logic     item_valid,
  input  logic     item_pop,
  output item_t    item
);

  item_t      slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign in_ready   = (count != 2'd2);
  assign item_valid = (count != 2'd0);
  assign item       = slots[rd_ptr];
  assign push       = in_valid && in_ready;
  assign pop        = item_pop && item_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr].clear <= (in_word.opcode == OP_CLEAR);
      slots[wr_ptr].word  <= in_word;
    end
  end

endmodule

// File: rtl/rrs_cordic.sv
// ----------------------------------------------------------------------------
// rrs_cordic: iterative sine and cosine
// Folds the angle into a half turn around zero and runs one rotation step
// per cycle; results in Q1.30.
// ----------------------------------------------------------------------------
module rrs_cordic import rrs_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [ANGLE_W-1:0]         angle,
  output logic                       done,
  output logic signed [CORDIC_W-1:0] sin_q30,
  output logic signed [CORDIC_W-1:0] cos_q30
);

  localparam logic signed [CORDIC_W-1:0] Q_TURN = 34'sd1073741824;
  localparam logic signed [CORDIC_W-1:0] H_TURN = 34'sd2147483648;

  logic signed [CORDIC_W-1:0] x;
  logic signed [CORDIC_W-1:0] y;
  logic signed [CORDIC_W-1:0] z;
  logic                       flip;
  logic                       busy;
  logic [STEP_W-1:0]          k;
  logic signed [COORD_W-1:0]  z32;
  logic signed [CORDIC_W-1:0] zw;
  logic signed [CORDIC_W-1:0] zf;
  logic                       flip_in;
  logic signed [CORDIC_W-1:0] xs;
  logic signed [CORDIC_W-1:0] ys;

  always_comb begin
    z32 = {angle, 16'h0000};
    zw  = CORDIC_W'(z32);
    zf  = zw;
    flip_in = 1'b0;
    if (zw > Q_TURN) begin
      zf = zw - H_TURN;
      flip_in = 1'b1;
    end else if (zw < -Q_TURN) begin
      zf = zw + H_TURN;
      flip_in = 1'b1;
    end
    xs = x >>> k;
    ys = y >>> k;
  end

  assign sin_q30 = flip ? -y : y;
  assign cos_q30 = flip ? -x : x;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      k    <= '0;
    end else begin
      done <= busy && !start && (k == STEP_W'(CORDIC_STEPS - 1));
      if (start) begin
        busy <= 1'b1;
        k    <= '0;
        x    <= CORDIC_X0;
        y    <= '0;
        z    <= zf;
        flip <= flip_in;
      end else if (busy) begin
        if (!z[CORDIC_W-1]) begin
          x <= x - ys;
          y <= y + xs;
          z <= z - atan_step(k);
        end else begin
          x <= x + ys;
          y <= y - xs;
          z <= z + atan_step(k);
        end
        k <= k + 1'b1;
        if (k == STEP_W'(CORDIC_STEPS - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

// File: rtl/rrs_edge.sv
// ----------------------------------------------------------------------------
// rrs_edge: ray against one obstacle edge
// Forms the exact cross products, applies the segment intersection rule and
// divides out the hit fraction one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rrs_edge import rrs_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  edge_req_t req,
  output logic      done,
  output edge_rsp_t rsp
);

  typedef enum logic [4:0] {
    E_IDLE = 5'b00001,
    E_MUL  = 5'b00010,
    E_SUB  = 5'b00100,
    E_CHK  = 5'b01000,
    E_DIV  = 5'b10000
  } edge_state_t;

  edge_state_t st;

  logic signed [COORD_W:0]   ex, ey, ox, oy;
  logic signed [RAY_W-1:0]   rx, ry;
  logic signed [66:0]        p_rey, p_exry, p_roy, p_rox, p_eoy, p_eyox;
  logic signed [PROD_W-1:0]  den, sn, tn;
  logic [REM_W-1:0]          mag, rem;
  logic [FRAC_W-1:0]         q;
  logic [4:0]                step;
  logic                      den_pos;
  logic                      reject;
  logic [PROD_W-1:0]         den_abs, tn_abs;
  logic [REM_W-1:0]          r2;
  logic                      ge;
  logic [FRAC_W-1:0]         q_fin;

  always_comb begin
    den_pos = !den[PROD_W-1];
    reject  = (den == '0) || (sn[PROD_W-1] == den_pos) || (tn[PROD_W-1] == den_pos)
              || ((sn > den) == den_pos) || ((tn > den) == den_pos);
    den_abs = den_pos ? den : -den;
    tn_abs  = tn[PROD_W-1] ? -tn : tn;
    r2      = (step == 5'd0) ? rem : {rem[REM_W-2:0], 1'b0};
    ge      = (r2 >= mag);
    q_fin   = {q[FRAC_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st   <= E_IDLE;
      done <= 1'b0;
    end else begin
      done <= ((st == E_CHK) && reject) ||
              ((st == E_DIV) && (step == 5'(DIV_STEPS - 1)));
      unique case (st)
        E_IDLE: begin
          if (start) begin
            ex <= (COORD_W+1)'(req.bx) - (COORD_W+1)'(req.ax);
            ey <= (COORD_W+1)'(req.by) - (COORD_W+1)'(req.ay);
            ox <= (COORD_W+1)'(req.px) - (COORD_W+1)'(req.ax);
            oy <= (COORD_W+1)'(req.py) - (COORD_W+1)'(req.ay);
            rx <= req.rx;
            ry <= req.ry;
            st <= E_MUL;
          end
        end
        E_MUL: begin
          p_rey  <= rx * ey;
          p_exry <= ex * ry;
          p_roy  <= rx * oy;
          p_rox  <= ry * ox;
          p_eoy  <= ex * oy;
          p_eyox <= ey * ox;
          st     <= E_SUB;
        end
        E_SUB: begin
          den <= PROD_W'(p_rey) - PROD_W'(p_exry);
          sn  <= PROD_W'(p_roy) - PROD_W'(p_rox);
          tn  <= PROD_W'(p_eoy) - PROD_W'(p_eyox);
          st  <= E_CHK;
        end
        E_CHK: begin
          if (reject) begin
            rsp.hit  <= 1'b0;
            rsp.frac <= FRAC_ONE;
            st       <= E_IDLE;
          end else begin
            mag  <= REM_W'(den_abs);
            rem  <= REM_W'(tn_abs);
            q    <= '0;
            step <= '0;
            st   <= E_DIV;
          end
        end
        E_DIV: begin
          rem  <= ge ? r2 - mag : r2;
          q    <= q_fin;
          step <= step + 5'd1;
          if (step == 5'(DIV_STEPS - 1)) begin
            rsp.hit  <= 1'b1;
            rsp.frac <= (q_fin > FRAC_ONE) ? FRAC_ONE : q_fin;
            st       <= E_IDLE;
          end
        end
        default: st <= E_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/rrs_checker.sv
// ----------------------------------------------------------------------------
// rrs_checker: port-level checks of the ray range sensor
// Output word stability, reset, ray ordering and the last flag.
// ----------------------------------------------------------------------------
module rrs_checker import rrs_pkg::*; #(
  parameter int SENSOR_COUNT = 32
) (
  input logic      clk,
  input logic      rst,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_word_t out_word
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_word))
    else $error("output word changed while stalled");

  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("bad state after reset");

  a_last: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_word.last == (out_word.ray_index == 6'(SENSOR_COUNT - 1))))
    else $error("last flag not on final ray");

  a_order: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !out_word.last) ##1 out_valid
      |-> out_word.ray_index == $past(out_word.ray_index) + 6'd1)
    else $error("ray index out of order");

endmodule

bind ray_range_sensor_update rrs_checker #(.SENSOR_COUNT(SENSOR_COUNT)) u_rrs_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_word  (out_word)
);

// File: dv/ray_range_sensor_update_checker.sv
// ----------------------------------------------------------------------------
// ray_range_sensor_update_checker: reading predictor and scoreboard
// Watches the input and output channels, keeps its own copy of the nearest-hit
// fractions and registers, predicts every reading and compares whole output words.
// ----------------------------------------------------------------------------
module ray_range_sensor_update_checker import rrs_pkg::*; #(
  parameter int SENSOR_COUNT = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  in_word_t              in_word,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  out_word_t             out_word,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    pending
);

  localparam longint ATAN_TBL [16] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
    83443, 41722, 20861
  };

  logic [LEN_W-1:0]     ray_len;
  logic [READING_W-1:0] scale;
  logic [FRAC_W-1:0]    nearest [SENSOR_COUNT];
  out_word_t            readings_q [$];

  assign pending = readings_q.size();

  task automatic report(input string what, input out_word_t got, input out_word_t want);
    fail_count++;
    $display("mismatch %s: got ray %0d reading %0d last %0d, want ray %0d reading %0d last %0d",
             what, got.ray_index, got.reading, got.last,
             want.ray_index, want.reading, want.last);
  endtask

  function automatic void cordic(input logic [ANGLE_W-1:0] ang, output longint s,
                                 output longint c);
    longint z, x, y, xs, ys;
    bit flip;
    z = longint'(ang) * 65536;
    x = 652032874;
    y = 0;
    flip = 0;
    if (z >= 64'sd2147483648) z -= 64'sd4294967296;
    if (z > 64'sd1073741824) begin
      z -= 64'sd2147483648; flip = 1;
    end else if (z < -64'sd1073741824) begin
      z += 64'sd2147483648; flip = 1;
    end
    for (int k = 0; k < 16; k++) begin
      xs = x >>> k;
      ys = y >>> k;
      if (z >= 0) begin
        x -= ys; y += xs; z -= ATAN_TBL[k];
      end else begin
        x += ys; y -= xs; z += ATAN_TBL[k];
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    s = y;
    c = x;
  endfunction

  function automatic bit edge_fraction(input longint px, py, rx, ry, ax, ay, bx, by,
                                       output logic [FRAC_W-1:0] frac);
    logic signed [127:0] ex, ey, ox, oy, den, sn, tn, mag, num, q;
    ex = bx - ax; ey = by - ay; ox = px - ax; oy = py - ay;
    den = 128'(rx) * ey - ex * 128'(ry);
    frac = FRAC_ONE;
    if (den == 0) return 0;
    sn = 128'(rx) * oy - 128'(ry) * ox;
    tn = ex * oy - ey * ox;
    if (den > 0) begin
      if (sn < 0 || tn < 0 || sn > den || tn > den) return 0;
    end else begin
      if (sn >= 0 || tn >= 0 || sn <= den || tn <= den) return 0;
    end
    mag = den < 0 ? -den : den;
    num = tn < 0 ? -tn : tn;
    q = (num <<< 16) / mag;
    frac = q > 65536 ? FRAC_ONE : q[FRAC_W-1:0];
    return 1;
  endfunction

  task automatic predict_readings(input in_word_t w);
    longint s, c, rx, ry, cx[4], cy[4];
    logic [ANGLE_W-1:0] ang;
    logic [FRAC_W-1:0] f, best;
    out_word_t r;
    if (w.opcode == OP_CLEAR) begin
      foreach (nearest[i]) nearest[i] = FRAC_ONE;
    end else begin
      cx = '{w.corner0_x, w.corner1_x, w.corner2_x, w.corner3_x};
      cy = '{w.corner0_y, w.corner1_y, w.corner2_y, w.corner3_y};
      for (int i = 0; i < SENSOR_COUNT; i++) begin
        ang = ANGLE_W'((i * 65536) / SENSOR_COUNT) - w.heading + QUARTER_TURN;
        cordic(ang, s, c);
        rx = (longint'(ray_len) * s) >>> 30;
        ry = (longint'(ray_len) * c) >>> 30;
        best = nearest[i];
        for (int e = 0; e < 4; e++)
          if (edge_fraction(w.pos_x, w.pos_y, rx, ry, cx[e], cy[e], cx[(e + 1) % 4],
                            cy[(e + 1) % 4], f) && f < best)
            best = f;
        nearest[i] = best;
      end
    end
    for (int i = 0; i < SENSOR_COUNT; i++) begin
      r.ray_index = 6'(i);
      r.reading = READING_W'((33'(scale) * nearest[i]) >> 16);
      r.last = (i == SENSOR_COUNT - 1);
      readings_q.push_back(r);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      ray_len <= SENSOR_LENGTH_RST;
      scale <= READING_SCALE_RST;
      foreach (nearest[i]) nearest[i] = FRAC_ONE;
      readings_q.delete();
      fail_count = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (readings_q.size() == 0) report("unexpected word", out_word, '0);
        else begin
          if (out_word !== readings_q[0]) report("field", out_word, readings_q[0]);
          void'(readings_q.pop_front());
        end
      end
      if (in_valid && in_ready) predict_readings(in_word);
      if (cfg_we) begin
        if (cfg_index == REG_SENSOR_LENGTH) ray_len <= cfg_data[LEN_W-1:0];
        else if (cfg_index == REG_READING_SCALE) scale <= cfg_data[READING_W-1:0];
      end
    end
  end

endmodule

// File: dv/ray_range_sensor_update_tb.sv
// ----------------------------------------------------------------------------
// ray_range_sensor_update_tb: stimulus and verdict for the ray range sensors
// Drives directed then random sense/clear words in bursts under several
// register settings, stalls the output side, and reports the checker verdict.
// ----------------------------------------------------------------------------
module ray_range_sensor_update_tb;
  import rrs_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;

  logic clk = 1'b0, rst = 1'b1;
  logic in_valid = 1'b0, in_ready, out_valid, out_ready = 1'b0;
  in_word_t in_word = '0;
  out_word_t out_word;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  int fail_count, pending, idle_cycles;
  bit hold_off = 0;

  ray_range_sensor_update DUT (.*);
  ray_range_sensor_update_checker CHK (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // output stall pattern: ready drawn at random, mostly high, held low while hold_off is set
  initial begin
    int run;
    forever begin
      @(negedge clk);
      if (hold_off) out_ready <= 1'b0;
      else begin
        run = $urandom_range(0, 3);
        out_ready <= (run != 0) || ($urandom_range(0, 9) < 2);
      end
    end
  end

  task automatic send(input in_word_t w);
    in_valid = 1'b1;
    in_word = w;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic drain();
    while (pending != 0) @(negedge clk);
    repeat (200) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] v);
    cfg_we = 1'b1; cfg_index = idx; cfg_data = v;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  function automatic logic signed [31:0] near_coord(input logic signed [31:0] c);
    return c + $signed($urandom_range(0, 32'h1_4000)) - 32'sh0_A000;
  endfunction

  // a random quadrilateral near the vehicle, or noise
  function automatic in_word_t rand_word();
    in_word_t w;
    logic [383:0] noise;
    noise = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
             $urandom, $urandom, $urandom, $urandom, $urandom};
    w = noise[$bits(in_word_t)-1:0];
    w.opcode = ($urandom_range(0, 9) == 0) ? OP_CLEAR : OP_SENSE;
    if ($urandom_range(0, 9) < 8) begin
      w.pos_x = $urandom_range(0, 1) ? $signed($urandom) : $signed($urandom_range(0, 32'hF_FFFF));
      w.pos_y = w.pos_y >>> $urandom_range(0, 31);
      w.corner0_x = near_coord(w.pos_x); w.corner0_y = near_coord(w.pos_y);
      w.corner1_x = near_coord(w.pos_x); w.corner1_y = near_coord(w.pos_y);
      w.corner2_x = near_coord(w.pos_x); w.corner2_y = near_coord(w.pos_y);
      w.corner3_x = near_coord(w.pos_x); w.corner3_y = near_coord(w.pos_y);
    end
    return w;
  endfunction

  // a clear word, answered at once, so the block fills quickly under stall
  function automatic in_word_t clear_word();
    in_word_t w;
    w = rand_word();
    w.opcode = OP_CLEAR;
    return w;
  endfunction

  initial begin
    in_word_t w;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    // directed: square around origin, axis-aligned edges, collinear, corners
    w = '0;
    w.opcode = OP_SENSE;
    w.corner0_x = -32'sh3_0000; w.corner0_y = -32'sh3_0000;
    w.corner1_x = 32'sh3_0000;  w.corner1_y = -32'sh3_0000;
    w.corner2_x = 32'sh3_0000;  w.corner2_y = 32'sh3_0000;
    w.corner3_x = -32'sh3_0000; w.corner3_y = 32'sh3_0000;
    send(w);
    w.heading = 16'hFFFF; send(w);
    w.heading = 16'h2000; send(w);
    w.corner1_x = 32'sh0; w.corner1_y = 32'sh0; send(w);   // vertex at the ray origin
    w.corner2_x = 32'sh5_0000; w.corner2_y = 32'sh0;       // edge along a ray
    w.corner1_x = 32'sh1_0000; w.heading = 16'h0; send(w);
    w = '0; w.corner0_x = 32'sh000A_0000; w.corner1_x = 32'sh000A_0000;
    w.corner1_y = 32'sh0001_0000; w.corner2_x = 32'sh000A_0000;
    w.corner2_y = -32'sh0001_0000; send(w);               // endpoint on ray tip
    w = '1; w.opcode = OP_CLEAR; send(w);
    w = '1; w.opcode = OP_SENSE; send(w);
    w = '0; w.pos_x = 32'sh7FFF_FFFF; w.pos_y = 32'sh8000_0000;
    w.corner0_x = 32'sh8000_0000; w.corner2_x = 32'sh7FFF_FFFF;
    w.corner1_y = 32'sh7FFF_FFFF; w.corner3_y = 32'sh8000_0000; send(w);
    drain();
    write_reg(REG_SENSOR_LENGTH, 31'h7FFF_FFFF);
    write_reg(REG_READING_SCALE, CFG_DATA_W'(16'd0));
    send(w);
    w.pos_x = 32'sh0; w.pos_y = 32'sh0; send(w);
    drain();
    write_reg(REG_SENSOR_LENGTH, 31'd0);
    write_reg(REG_READING_SCALE, CFG_DATA_W'(16'd1));
    w.opcode = OP_CLEAR; send(w);
    w.opcode = OP_SENSE; send(w);
    drain();
    write_reg(REG_READING_SCALE, CFG_DATA_W'(16'hFFFF));
    write_reg(REG_SENSOR_LENGTH, 31'h000F_0000);
    w.opcode = OP_CLEAR; send(w);
    // random phases with varied settings
    for (int phase = 0; phase < 4; phase++) begin
      if (phase != 0) begin
        drain();
        write_reg(REG_SENSOR_LENGTH, phase == 3 ? 31'h7FFF_FFFF :
                  CFG_DATA_W'($urandom_range(0, 31'h20_0000)));
        write_reg(REG_READING_SCALE, CFG_DATA_W'($urandom_range(0, 16'hFFFF)));
      end
      if (phase == 1) begin
        fork
          begin
            hold_off = 1;
            repeat (600) @(negedge clk);
            hold_off = 0;
          end
          for (int n = 0; n < 5; n++) send(clear_word());
        join
      end
      for (int n = 0; n < 60; n++) begin
        if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 30)) @(negedge clk);
        send(rand_word());
      end
    end
    drain();
    if (fail_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
